// ===== src/bap_pkg.sv =====
// Shared types and constants for the block-average pixelate filter.
`timescale 1ns / 1ps

package bap_pkg;

    localparam int MAX_DIMENSION_DEF   = 4096;
    localparam int BLOCKS_PER_AXIS_DEF = 64;

    localparam int SIDE_W      = 13;
    localparam int DENOM_W     = 7;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int SLOT_W      = 16;
    localparam int SUM_W       = 32;
    localparam int COUNT_W     = 25;
    localparam int CHAN_W      = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DENOM  = 2'd2;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_EMIT  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] alpha_in;
    } pix_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] alpha_out;
        logic              frame_end;
        logic              grid_overflow;
    } res_t;

    typedef struct packed {
        logic              op;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [SLOT_W-1:0] slot;
        logic              active;
        logic              overflow;
        logic              last_pixel;
    } work_t;

    typedef struct packed {
        logic [SUM_W-1:0]   red_sum;
        logic [SUM_W-1:0]   green_sum;
        logic [SUM_W-1:0]   blue_sum;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

// ===== src/bap_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bap_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       shifted;
    logic [W:0]       trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the trial difference when it does not borrow
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/bap_front.sv =====
// Front end: configuration, raster position tracking and block classification.
`timescale 1ns / 1ps

module bap_front #(
    parameter int MAX_DIMENSION   = 4096,
    parameter int BLOCKS_PER_AXIS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  bap_pkg::pix_t                    pix,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bap_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bap_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  bap_pkg::queue_status_t           qstat,
    input  bap_pkg::back_status_t            bstat,
    output logic                             push,
    output bap_pkg::work_t                   work
);
    import bap_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int POS_W  = $clog2(MAX_DIMENSION);
    localparam int FDIV_W = (DIM_W > DENOM_W) ? DIM_W : DENOM_W;
    localparam int EXT_W  = (DIM_W > SIDE_W) ? DIM_W : SIDE_W;
    localparam int BPA_W  = $clog2(BLOCKS_PER_AXIS + 1);
    localparam int CMP_W  = (POS_W > BPA_W) ? POS_W : BPA_W;
    localparam int G_W    = DIM_W + BPA_W;

    typedef enum logic [2:0] {
        F_RUN, F_EDGE_GO, F_EDGE_WAIT, F_COL_GO, F_COL_WAIT, F_ROW_GO, F_ROW_WAIT
    } fstate_t;

    fstate_t             state_reg, state_next;
    logic [SIDE_W-1:0]   width_reg, width_next;
    logic [SIDE_W-1:0]   height_reg, height_next;
    logic [DENOM_W-1:0]  denom_reg, denom_next;
    logic [DIM_W-1:0]    edge_reg, edge_next;
    logic [POS_W-1:0]    col_reg, col_next, row_reg, row_next;
    logic [POS_W-1:0]    bx_reg, bx_next, by_reg, by_next;
    logic [POS_W-1:0]    cofs_reg, cofs_next, rofs_reg, rofs_next;
    logic                phase_reg, phase_next;

    logic [DIM_W-1:0]    w_side, h_side, larger;
    logic [POS_W-1:0]    e_col, e_row, e_bx, e_by, e_cofs, e_rofs;
    logic                restart, edge_on, grid_big, off_table;
    logic                active, overflow, last_col, last_pixel, accept, cfg_write;
    logic                div_start, div_done;
    logic [FDIV_W-1:0]   div_num, div_den, div_q, div_r;

    function automatic logic [DIM_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        if (e == '0)
            e = EXT_W'(1);
        else if (e > EXT_W'(MAX_DIMENSION))
            e = EXT_W'(MAX_DIMENSION);
        return DIM_W'(e);
    endfunction

    assign w_side    = clamp_side(width_reg);
    assign h_side    = clamp_side(height_reg);
    assign larger    = (w_side > h_side) ? w_side : h_side;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign pix_stall = (state_reg != F_RUN) || qstat.full || bstat.init_busy;
    assign accept    = pix_valid && !pix_stall;
    assign push      = accept;

    // divider operands follow the setup step
    always_comb
    begin
        div_start = 1'b0;
        div_num   = FDIV_W'(larger);
        div_den   = FDIV_W'(denom_reg);
        case (state_reg)
            F_EDGE_GO:
            begin
                div_start = (denom_reg != '0);
            end
            F_COL_GO:
            begin
                div_start = 1'b1;
                div_num   = FDIV_W'(col_reg);
                div_den   = FDIV_W'(edge_reg);
            end
            F_ROW_GO:
            begin
                div_start = 1'b1;
                div_num   = FDIV_W'(row_reg);
                div_den   = FDIV_W'(edge_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    bap_div #(.W(FDIV_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (div_den),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // classify the incoming pixel
    always_comb
    begin
        restart    = (pix.op != phase_reg);
        e_col      = restart ? '0 : col_reg;
        e_row      = restart ? '0 : row_reg;
        e_bx       = restart ? '0 : bx_reg;
        e_by       = restart ? '0 : by_reg;
        e_cofs     = restart ? '0 : cofs_reg;
        e_rofs     = restart ? '0 : rofs_reg;
        edge_on    = (edge_reg != '0);
        grid_big   = (G_W'(w_side) > G_W'(BLOCKS_PER_AXIS) * G_W'(edge_reg)) ||
                     (G_W'(h_side) > G_W'(BLOCKS_PER_AXIS) * G_W'(edge_reg));
        off_table  = (CMP_W'(e_bx) >= CMP_W'(BLOCKS_PER_AXIS)) ||
                     (CMP_W'(e_by) >= CMP_W'(BLOCKS_PER_AXIS));
        overflow   = edge_on && (grid_big || off_table);
        active     = edge_on && !(grid_big || off_table);
        last_col   = (DIM_W'(e_col) + DIM_W'(1)) >= w_side;
        last_pixel = last_col && ((DIM_W'(e_row) + DIM_W'(1)) >= h_side);

        work.op         = pix.op;
        work.red        = pix.red_in;
        work.green      = pix.green_in;
        work.blue       = pix.blue_in;
        work.alpha      = pix.alpha_in;
        work.slot       = active ? SLOT_W'(SLOT_W'(e_by) * SLOT_W'(BLOCKS_PER_AXIS)
                                           + SLOT_W'(e_bx)) : '0;
        work.active     = active;
        work.overflow   = overflow;
        work.last_pixel = last_pixel;
    end

    always_comb
    begin
        state_next  = state_reg;
        width_next  = width_reg;
        height_next = height_reg;
        denom_next  = denom_reg;
        edge_next   = edge_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        cofs_next   = cofs_reg;
        rofs_next   = rofs_reg;
        phase_next  = phase_reg;
        case (state_reg)
            F_RUN:
            begin
                if (accept)
                begin
                    col_next  = e_col;
                    row_next  = e_row;
                    bx_next   = e_bx;
                    by_next   = e_by;
                    cofs_next = e_cofs;
                    rofs_next = e_rofs;
                    phase_next = pix.op;
                    if (last_pixel)
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        bx_next    = '0;
                        by_next    = '0;
                        cofs_next  = '0;
                        rofs_next  = '0;
                        phase_next = (pix.op == OP_ACCUM) ? OP_EMIT : OP_ACCUM;
                    end
                    else if (last_col)
                    begin
                        col_next  = '0;
                        bx_next   = '0;
                        cofs_next = '0;
                        row_next  = e_row + POS_W'(1);
                        if ((DIM_W'(e_rofs) + DIM_W'(1)) == edge_reg)
                        begin
                            rofs_next = '0;
                            by_next   = e_by + POS_W'(1);
                        end
                        else
                        begin
                            rofs_next = e_rofs + POS_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = e_col + POS_W'(1);
                        if ((DIM_W'(e_cofs) + DIM_W'(1)) == edge_reg)
                        begin
                            cofs_next = '0;
                            bx_next   = e_bx + POS_W'(1);
                        end
                        else
                        begin
                            cofs_next = e_cofs + POS_W'(1);
                        end
                    end
                end
            end
            F_EDGE_GO:
            begin
                if (denom_reg == '0)
                begin
                    edge_next  = '0;
                    state_next = F_RUN;
                end
                else
                begin
                    state_next = F_EDGE_WAIT;
                end
            end
            F_EDGE_WAIT:
            begin
                if (div_done)
                begin
                    edge_next  = DIM_W'(div_q);
                    state_next = (div_q == '0) ? F_RUN : F_COL_GO;
                end
            end
            F_COL_GO:
            begin
                state_next = F_COL_WAIT;
            end
            F_COL_WAIT:
            begin
                if (div_done)
                begin
                    bx_next    = POS_W'(div_q);
                    cofs_next  = POS_W'(div_r);
                    state_next = F_ROW_GO;
                end
            end
            F_ROW_GO:
            begin
                state_next = F_ROW_WAIT;
            end
            F_ROW_WAIT:
            begin
                if (div_done)
                begin
                    by_next    = POS_W'(div_q);
                    rofs_next  = POS_W'(div_r);
                    state_next = F_RUN;
                end
            end
            default:
            begin
                state_next = F_EDGE_GO;
            end
        endcase
        // any register write reruns the block geometry setup
        if (cfg_write)
        begin
            state_next = F_EDGE_GO;
            case (cfg_index)
                CFG_WIDTH:  width_next  = SIDE_W'(cfg_data);
                CFG_HEIGHT: height_next = SIDE_W'(cfg_data);
                CFG_DENOM:  denom_next  = DENOM_W'(cfg_data);
                default:    denom_next  = denom_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_EDGE_GO;
            width_reg  <= SIDE_W'(1);
            height_reg <= SIDE_W'(1);
            denom_reg  <= '0;
            edge_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            bx_reg     <= '0;
            by_reg     <= '0;
            cofs_reg   <= '0;
            rofs_reg   <= '0;
            phase_reg  <= OP_ACCUM;
        end
        else
        begin
            state_reg  <= state_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            denom_reg  <= denom_next;
            edge_reg   <= edge_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            bx_reg     <= bx_next;
            by_reg     <= by_next;
            cofs_reg   <= cofs_next;
            rofs_reg   <= rofs_next;
            phase_reg  <= phase_next;
        end
    end

endmodule

// ===== src/bap_queue.sv =====
// Short work queue between the front and back ends.
`timescale 1ns / 1ps

module bap_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  bap_pkg::work_t         work_in,
    input  logic                   pop,
    output bap_pkg::work_t         work_out,
    output bap_pkg::queue_status_t qstat
);
    import bap_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t            slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        if (pop)
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_reg] <= work_in;
    end

    assign work_out    = slots[rd_reg];
    assign qstat.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (cnt_reg == '0);

endmodule

// ===== src/bap_back.sv =====
// Back end: block sum table, averaging dividers and result register.
`timescale 1ns / 1ps

module bap_back #(
    parameter int BLOCKS_PER_AXIS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bap_pkg::queue_status_t qstat,
    output logic                   pop,
    input  bap_pkg::work_t         work,
    output bap_pkg::back_status_t  bstat,
    output logic                   res_valid,
    input  logic                   res_stall,
    output bap_pkg::res_t          res
);
    import bap_pkg::*;

    localparam int DEPTH  = BLOCKS_PER_AXIS * BLOCKS_PER_AXIS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        B_INIT, B_IDLE, B_READ, B_CALC, B_DIV, B_OUT, B_CLEAR
    } bstate_t;

    bstate_t           state_reg, state_next;
    work_t             item_reg, item_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    res_t              hold_reg, hold_next;
    res_t              res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    entry_t            mem [DEPTH];
    entry_t            rd_data_reg;
    entry_t            mem_wdata;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_we;

    logic              div_start, div_done;
    logic [SUM_W-1:0]  q_red, q_green, q_blue;
    logic [SUM_W-1:0]  div_den;

    assign pop             = (state_reg == B_IDLE) && !qstat.empty;
    assign bstat.init_busy = (state_reg == B_INIT);
    assign div_den         = SUM_W'(rd_data_reg.count);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[item_reg.slot[ADDR_W-1:0]];
    end

    bap_div #(.W(SUM_W)) u_div_red (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .dividend (rd_data_reg.red_sum), .divisor (div_den),
        .done (div_done), .quotient (q_red), .remainder ()
    );

    bap_div #(.W(SUM_W)) u_div_green (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .dividend (rd_data_reg.green_sum), .divisor (div_den),
        .done (), .quotient (q_green), .remainder ()
    );

    bap_div #(.W(SUM_W)) u_div_blue (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .dividend (rd_data_reg.blue_sum), .divisor (div_den),
        .done (), .quotient (q_blue), .remainder ()
    );

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        clr_next       = clr_reg;
        hold_next      = hold_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        mem_we         = 1'b0;
        mem_waddr      = item_reg.slot[ADDR_W-1:0];
        mem_wdata      = rd_data_reg;
        div_start      = 1'b0;
        case (state_reg)
            B_INIT, B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                if (pop)
                begin
                    item_next  = work;
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_CALC;
            end
            B_CALC:
            begin
                hold_next.red_out       = item_reg.red;
                hold_next.green_out     = item_reg.green;
                hold_next.blue_out      = item_reg.blue;
                hold_next.alpha_out     = item_reg.alpha;
                hold_next.frame_end     = item_reg.last_pixel;
                hold_next.grid_overflow = item_reg.overflow;
                if (item_reg.op == OP_ACCUM)
                begin
                    mem_we              = item_reg.active;
                    mem_wdata.red_sum   = rd_data_reg.red_sum + SUM_W'(item_reg.red);
                    mem_wdata.green_sum = rd_data_reg.green_sum + SUM_W'(item_reg.green);
                    mem_wdata.blue_sum  = rd_data_reg.blue_sum + SUM_W'(item_reg.blue);
                    mem_wdata.count     = rd_data_reg.count + COUNT_W'(1);
                    state_next          = B_IDLE;
                end
                else if (item_reg.active && (rd_data_reg.count != '0))
                begin
                    div_start  = 1'b1;
                    state_next = B_DIV;
                end
                else
                begin
                    state_next = B_OUT;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    hold_next.red_out   = q_red[CHAN_W-1:0];
                    hold_next.green_out = q_green[CHAN_W-1:0];
                    hold_next.blue_out  = q_blue[CHAN_W-1:0];
                    state_next          = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next       = hold_reg;
                    res_valid_next = 1'b1;
                    if (item_reg.last_pixel)
                    begin
                        clr_next   = '0;
                        state_next = B_CLEAR;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        hold_reg <= hold_next;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE) |-> !mem_we)
        else $error("table written while idle");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == B_DIV))
        else $error("divider finished outside the divide step");

    a_res_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == B_OUT))
        else $error("result raised outside the output step");
`endif

endmodule

// ===== src/block_average_pixelate.sv =====
// Top level of the block-average pixelate filter.
// An accumulate beat passes the queue and the back end's idle, read and calc states; calc writes the table.
// An emit beat also passes the divide state if averaged, then the output state; one beat at a time.
// The end of each emit pass sweeps all BLOCKS_PER_AXIS^2 entries of the sum table (4096 by default).
// Reset clears control state and runs the same table sweep before pixels are taken.
// Every register write reruns block geometry setup, up to three divisions.
`timescale 1ns / 1ps

module block_average_pixelate #(
    parameter int MAX_DIMENSION   = bap_pkg::MAX_DIMENSION_DEF,
    parameter int BLOCKS_PER_AXIS = bap_pkg::BLOCKS_PER_AXIS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    output logic                            pix_stall,
    input  bap_pkg::pix_t                   pix,
    output logic                            res_valid,
    input  logic                            res_stall,
    output bap_pkg::res_t                   res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bap_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bap_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bap_pkg::*;

    // front end classifies each beat; the queue decouples it from the table work
    work_t         push_work, pop_work;
    logic          push, pop;
    queue_status_t qstat;
    back_status_t  bstat;

    bap_front #(
        .MAX_DIMENSION   (MAX_DIMENSION),
        .BLOCKS_PER_AXIS (BLOCKS_PER_AXIS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .bstat     (bstat),
        .push      (push),
        .work      (push_work)
    );

    // hold up to two classified beats
    bap_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .work_in  (push_work),
        .pop      (pop),
        .work_out (pop_work),
        .qstat    (qstat)
    );

    // read-modify-write the block sums, average on emit, drive the result register
    bap_back #(
        .BLOCKS_PER_AXIS (BLOCKS_PER_AXIS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .pop       (pop),
        .work      (pop_work),
        .bstat     (bstat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
